// File: sv/segment_box_slab_test_macros.svh
// assertion macros for the segment box slab test checker
// needs signals named clock and reset in the scope of use
`ifndef SEGMENT_BOX_SLAB_TEST_MACROS_SVH
`define SEGMENT_BOX_SLAB_TEST_MACROS_SVH

// implication checked in the same cycle, off during reset
`define SBST_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbst assertion failed");

// implication checked in the next cycle, also active during reset
`define SBST_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sbst assertion failed");

`endif

// File: sv/sbst_pkg.sv
// shared types and constants for the segment box slab test
// no dependencies
`default_nettype none
package sbst_pkg;
   localparam int PARAM_WIDTH = 32;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam logic signed [PARAM_WIDTH-1:0] PARAM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PARAM_WIDTH-1:0] PARAM_MIN = 32'sh8000_0000;

   // per transaction flags that ride beside the dividers
   typedef struct packed {
      logic [2:0] par;
      logic       bad;
   } sbst_side_type;

   // divider latency: magnitude stage, quotient stages, saturation stage
   function automatic int div_latency(input int cw, input int fb);
      return (cw + 1 + fb + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE + 2;
   endfunction
endpackage
`default_nettype wire

// File: sv/segment_box_slab_test.sv
// top level of the segment versus axis aligned box slab test
// depends on sbst_pkg and sbst_divider
//
// channel   ports          handshake
// request   start, req_*   taken when start is high and busy is low
// response  rsp_*          one cycle strobe on rsp_valid, no backpressure
//
// the delay is set by the quotient stages of the six dividers at two
// quotient bits per stage, after the input register and before stages a, b and c
// a new transaction is taken every cycle, busy stays low
// reset is synchronous and clears only the valid bits
// the receiver cannot stall, so nothing in the pipe ever waits
`default_nettype none
module segment_box_slab_test #(
   parameter int COORD_WIDTH     = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_z,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_delta_x,
   input  logic signed [COORD_WIDTH-1:0] req_delta_y,
   input  logic signed [COORD_WIDTH-1:0] req_delta_z,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic signed [sbst_pkg::PARAM_WIDTH-1:0] rsp_entry_param
);
   import sbst_pkg::*;

   localparam int LAT = div_latency(COORD_WIDTH, PARAM_FRAC_BITS);
   localparam logic signed [PARAM_WIDTH-1:0] ONE =
      PARAM_WIDTH'(64'd1 << PARAM_FRAC_BITS);

   // fully pipelined, never refuses a transaction
   assign busy = 1'b0;

   logic signed [COORD_WIDTH-1:0] bmin [0:2];
   logic signed [COORD_WIDTH-1:0] bmax [0:2];
   logic signed [COORD_WIDTH-1:0] org  [0:2];
   logic signed [COORD_WIDTH-1:0] dlt  [0:2];

   assign bmin[0] = req_box_min_x;  assign bmin[1] = req_box_min_y;
   assign bmin[2] = req_box_min_z;
   assign bmax[0] = req_box_max_x;  assign bmax[1] = req_box_max_y;
   assign bmax[2] = req_box_max_z;
   assign org[0]  = req_start_x;    assign org[1]  = req_start_y;
   assign org[2]  = req_start_z;
   assign dlt[0]  = req_delta_x;    assign dlt[1]  = req_delta_y;
   assign dlt[2]  = req_delta_z;

   // stage 0: slab numerators, parallel axis flags and containment
   logic                          v0_ff;
   logic signed [COORD_WIDTH:0]   num_ff [0:5];
   logic signed [COORD_WIDTH-1:0] den_ff [0:2];
   sbst_side_type                 side_in;
   sbst_side_type                 side_ff [0:LAT];

   always_comb begin
      side_in.bad = 1'b0;
      for (int a = 0; a < 3; a++) begin
         side_in.par[a] = (dlt[a] == '0);
         // a parallel axis misses unless the start lies inside its slab
         if (side_in.par[a] && (org[a] < bmin[a] || org[a] > bmax[a]))
            side_in.bad = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      v0_ff      <= reset ? 1'b0 : start;
      for (int a = 0; a < 3; a++) begin
         num_ff[2*a]   <= (COORD_WIDTH+1)'(bmin[a]) - (COORD_WIDTH+1)'(org[a]);
         num_ff[2*a+1] <= (COORD_WIDTH+1)'(bmax[a]) - (COORD_WIDTH+1)'(org[a]);
         den_ff[a]     <= dlt[a];
      end
   end

   // six dividers, one per slab plane
   logic                          div_v [0:5];
   logic signed [PARAM_WIDTH-1:0] div_q [0:5];

   for (genvar i = 0; i < 6; i++) begin : g_div
      sbst_divider #(
         .COORD_WIDTH     (COORD_WIDTH),
         .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v0_ff),
         .in_num    (num_ff[i]),
         .in_den    (den_ff[i/2]),
         .out_valid (div_v[i]),
         .out_quot  (div_q[i])
      );
   end

   // flags follow the dividers
   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int s = 0; s < LAT; s++) side_ff[s+1] <= side_ff[s];
   end

   logic div_valid;
   assign div_valid = div_v[0] & div_v[1] & div_v[2] & div_v[3] & div_v[4] & div_v[5];

   // stage a: order each slab pair, parallel axes span the whole range
   logic                          va_ff;
   logic                          bad_a_ff;
   logic signed [PARAM_WIDTH-1:0] near_ff [0:2];
   logic signed [PARAM_WIDTH-1:0] far_ff  [0:2];

   always_ff @(posedge clock) begin
      va_ff    <= reset ? 1'b0 : div_valid;
      bad_a_ff <= side_ff[LAT].bad;
      for (int a = 0; a < 3; a++) begin
         if (side_ff[LAT].par[a]) begin
            near_ff[a] <= PARAM_MIN;
            far_ff[a]  <= PARAM_MAX;
         end else if (div_q[2*a] < div_q[2*a+1]) begin
            near_ff[a] <= div_q[2*a];
            far_ff[a]  <= div_q[2*a+1];
         end else begin
            near_ff[a] <= div_q[2*a+1];
            far_ff[a]  <= div_q[2*a];
         end
      end
   end

   // stage b: largest entry, smallest exit
   logic                          vb_ff;
   logic                          bad_b_ff;
   logic signed [PARAM_WIDTH-1:0] entry_in, exit_in;
   logic signed [PARAM_WIDTH-1:0] entry_ff, exit_ff;

   always_comb begin
      entry_in = near_ff[0];
      exit_in  = far_ff[0];
      for (int a = 1; a < 3; a++) begin
         if (near_ff[a] > entry_in) entry_in = near_ff[a];
         if (far_ff[a] < exit_in)   exit_in  = far_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      vb_ff    <= reset ? 1'b0 : va_ff;
      bad_b_ff <= bad_a_ff;
      entry_ff <= entry_in;
      exit_ff  <= exit_in;
   end

   // stage c: overlap must touch the segment range [0,1]
   logic                          hit_in;
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic signed [PARAM_WIDTH-1:0] rsp_entry_ff;

   assign hit_in = !bad_b_ff && (entry_ff <= exit_ff) && (entry_ff <= ONE)
                   && (exit_ff >= 0);

   always_ff @(posedge clock) begin
      rsp_valid_ff <= reset ? 1'b0 : vb_ff;
      rsp_hit_ff   <= hit_in;
      rsp_entry_ff <= hit_in ? entry_ff : '0;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_param = rsp_entry_ff;
endmodule
`default_nettype wire

// File: sv/sbst_divider.sv
// pipelined signed divider, truncating, quotient saturated to 32 bits
// depends on sbst_pkg
`default_nettype none
module sbst_divider #(
   parameter int COORD_WIDTH     = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH:0]   in_num,
   input  logic signed [COORD_WIDTH-1:0] in_den,
   output logic                          out_valid,
   output logic signed [sbst_pkg::PARAM_WIDTH-1:0] out_quot
);
   import sbst_pkg::*;

   localparam int NW  = COORD_WIDTH + 1 + PARAM_FRAC_BITS;
   localparam int RW  = COORD_WIDTH + 1;
   localparam int NST = (NW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int EW  = (NW > PARAM_WIDTH + 1) ? NW : PARAM_WIDTH + 1;

   logic                   v_ff   [0:NST];
   logic [RW-1:0]          rem_ff [0:NST];
   logic [NW-1:0]          nq_ff  [0:NST];
   logic [COORD_WIDTH-1:0] den_ff [0:NST];
   logic                   neg_ff [0:NST];

   logic [COORD_WIDTH:0]   nraw;
   logic [COORD_WIDTH:0]   nmag;
   logic [COORD_WIDTH-1:0] draw;
   logic [COORD_WIDTH-1:0] dmag;

   // magnitudes and result sign
   assign nraw = in_num;
   assign draw = in_den;
   assign nmag = nraw[COORD_WIDTH] ? (~nraw + 1'b1) : nraw;
   assign dmag = draw[COORD_WIDTH-1] ? (~draw + 1'b1) : draw;

   always_ff @(posedge clock) begin
      v_ff[0]   <= reset ? 1'b0 : in_valid;
      rem_ff[0] <= '0;
      nq_ff[0]  <= {nmag, {PARAM_FRAC_BITS{1'b0}}};
      den_ff[0] <= dmag;
      neg_ff[0] <= nraw[COORD_WIDTH] ^ draw[COORD_WIDTH-1];
   end

   // restoring division, two quotient bits per stage
   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic [NW-1:0] nq_in;
      logic [RW-1:0] cand;
      always_comb begin
         rem_in = rem_ff[s];
         nq_in  = nq_ff[s];
         cand   = '0;
         for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            if (s * DIV_BITS_PER_STAGE + k < NW) begin
               cand = {rem_in[RW-2:0], nq_in[NW-1]};
               if (cand >= {1'b0, den_ff[s]}) begin
                  rem_in = cand - {1'b0, den_ff[s]};
                  nq_in  = {nq_in[NW-2:0], 1'b1};
               end else begin
                  rem_in = cand;
                  nq_in  = {nq_in[NW-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         v_ff[s+1]   <= reset ? 1'b0 : v_ff[s];
         rem_ff[s+1] <= rem_in;
         nq_ff[s+1]  <= nq_in;
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   // sign and saturation
   logic [EW-1:0]                mag;
   logic signed [PARAM_WIDTH-1:0] quot_in;
   logic                         valid_ff;
   logic signed [PARAM_WIDTH-1:0] quot_ff;

   assign mag = EW'(nq_ff[NST]);

   always_comb begin
      if (!neg_ff[NST]) begin
         if (mag > EW'(PARAM_MAX)) quot_in = PARAM_MAX;
         else                      quot_in = mag[PARAM_WIDTH-1:0];
      end else begin
         if (mag > EW'({1'b1, {(PARAM_WIDTH-1){1'b0}}})) quot_in = PARAM_MIN;
         else quot_in = ~mag[PARAM_WIDTH-1:0] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= reset ? 1'b0 : v_ff[NST];
      quot_ff  <= quot_in;
   end

   assign out_valid = valid_ff;
   assign out_quot  = quot_ff;
endmodule
`default_nettype wire

// File: sv/sbst_checker.sv
// port level checks on the segment box slab test, bound to the top level
// depends on sbst_pkg and segment_box_slab_test_macros.svh
`default_nettype none
`include "segment_box_slab_test_macros.svh"
module sbst_checker #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_hit,
   input logic signed [sbst_pkg::PARAM_WIDTH-1:0] rsp_entry_param
);
   import sbst_pkg::*;

   localparam logic signed [PARAM_WIDTH-1:0] ONE =
      PARAM_WIDTH'(64'd1 << PARAM_FRAC_BITS);

   // a miss carries a zero entry parameter
   `SBST_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp_hit, rsp_entry_param == '0)
   // a hit never enters past the segment end
   `SBST_ASSERT_IMP(a_hit_range, rsp_valid && rsp_hit, rsp_entry_param <= ONE)
   // reset empties the pipe
   `SBST_ASSERT_NXT(a_reset_quiet, reset, !rsp_valid)
   // pipelined, so a transaction is never refused
   `SBST_ASSERT_IMP(a_never_busy, start, !busy)
endmodule

bind segment_box_slab_test sbst_checker #(
   .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_sbst_checker (.*);
`default_nettype wire
